// ===== sv/tlbpt_pkg.sv =====
// Package for the TLB page translator: sizes, action and status codes.
// No dependencies.
`timescale 1ns / 1ps
package tlbpt_pkg;
  localparam int TlbSize = 8;
  localparam int ProcessCount = 4;
  localparam int PagesPerProcess = 256;
  localparam int FrameWidth = 16;
  localparam int TimeWidth = 32;

  localparam logic [1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [1:0] ACT_MAP = 2'd1;
  localparam logic [1:0] ACT_UNMAP = 2'd2;
  localparam logic [1:0] ACT_SWITCH = 2'd3;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_FAULT = 3'd2;
  localparam logic [2:0] ST_MAPPED = 3'd3;
  localparam logic [2:0] ST_UNMAPPED = 3'd4;
  localparam logic [2:0] ST_NOOP = 3'd5;
  localparam logic [2:0] ST_BADPROC = 3'd6;

  localparam logic REG_OFFSET_BITS = 1'b0;
  localparam logic REG_POLICY = 1'b1;
endpackage

// ===== sv/tlbpt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tlbpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/tlb_page_translator_core.sv =====
// Top level of the TLB page translator: sequencer, TLB entry registers,
// page-table memories. Uses tlbpt_pkg and tlbpt_ram.
`timescale 1ns / 1ps
// One item at a time. Each item steps through a state that presents the
// page-table address, one step per TLB entry through a single shared compare
// unit that finds the match and the replacement victim (the page-table read
// is latched in the first of them), an update state, a result state and
// the idle state in which the next item is taken. The block stays busy for
// as long as m_tready holds off the result.
// After reset a clearing pass runs once over every entry of the page-table
// valid memory, during which no item is taken.
module tlb_page_translator_core #(
  parameter int TLB_SIZE = tlbpt_pkg::TlbSize,
  parameter int PROCESS_COUNT = tlbpt_pkg::ProcessCount,
  parameter int PAGES_PER_PROCESS = tlbpt_pkg::PagesPerProcess,
  parameter int FRAME_WIDTH = tlbpt_pkg::FrameWidth,
  parameter int TIME_WIDTH = tlbpt_pkg::TimeWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], virt_addr[21:2], page_number[29:22],
  // frame_number[45:30], new_process[48:46], zero fill
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], phys_addr[30:3], entry_index[33:31],
  // frame_out[49:34], page_out[57:50], process_out[59:58], zero fill
  output logic [63:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  localparam int IW = $clog2(TLB_SIZE);
  localparam int PW = $clog2(PAGES_PER_PROCESS);
  localparam int CW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int TD = PROCESS_COUNT * PAGES_PER_PROCESS;
  localparam int AW = $clog2(TD);
  localparam int FW = FRAME_WIDTH;
  localparam int TW = TIME_WIDTH;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_UPD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [3:0] offset_bits;
  logic       policy;
  logic [CW-1:0] cur_proc;
  logic [TW-1:0] tick;
  logic [AW:0]   clr_cnt;

  logic [TLB_SIZE-1:0] e_valid;
  logic [7:0]    e_page [TLB_SIZE];
  logic [FW-1:0] e_frame [TLB_SIZE];
  logic [CW-1:0] e_owner [TLB_SIZE];
  logic [TW-1:0] e_ins [TLB_SIZE];
  logic [TW-1:0] e_use [TLB_SIZE];

  logic [1:0]  act;
  logic [19:0] vaddr;
  logic [7:0]  page;
  logic [FW-1:0] frame_in;
  logic [2:0]  target;
  logic [3:0]  ob;
  logic        in_range;
  logic [PW-1:0] pidx;

  logic [IW:0]   scan;
  logic          found, free_found;
  logic [IW-1:0] hit_idx, pick;
  logic [TW-1:0] oldest;
  logic          tv;
  logic [FW-1:0] tf;

  logic [2:0]  r_status;
  logic [27:0] r_paddr;
  logic [2:0]  r_idx;
  logic [15:0] r_fout;
  logic [7:0]  r_pout;

  // page table memories
  logic          v_we, f_we, v_wd, v_rd;
  logic [AW-1:0] t_addr, v_addr;
  logic [FW-1:0] f_wd, f_rd;

  assign v_addr = (state == S_CLEAR) ? clr_cnt[AW-1:0] : t_addr;
  tlbpt_ram #(.Width(1), .Depth(TD)) u_valid (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
  tlbpt_ram #(.Width(FW), .Depth(TD)) u_frame (
    .clk(clk), .we(f_we), .addr(t_addr), .wdata(f_wd), .rdata(f_rd));

  logic [3:0] cob;
  assign cob = (offset_bits > 4'd12) ? 4'd12 : offset_bits;
  logic [19:0] vpn;
  assign vpn = vaddr >> ob;
  logic [19:0] pg_full;
  assign pg_full = (act == tlbpt_pkg::ACT_TRANSLATE) ? vpn : {12'd0, page};

  always_comb begin
    in_range = pg_full < 20'(PAGES_PER_PROCESS);
    pidx = pg_full[PW-1:0];
    t_addr = AW'(cur_proc) * AW'(PAGES_PER_PROCESS) + AW'(pidx);
  end

  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  logic [IW-1:0] si;
  assign si = scan[IW-1:0];
  logic match_i;
  assign match_i = e_valid[si] && (e_page[si] == 8'(pidx)) && (e_owner[si] == cur_proc);

  // update decisions
  logic is_tr, is_map, is_unmap;
  assign is_tr = (act == tlbpt_pkg::ACT_TRANSLATE);
  assign is_map = (act == tlbpt_pkg::ACT_MAP);
  assign is_unmap = (act == tlbpt_pkg::ACT_UNMAP);
  logic do_insert;
  assign do_insert = in_range && (is_map || (is_tr && !found && tv));
  logic [IW-1:0] ins_idx;
  assign ins_idx = found ? hit_idx : pick;
  logic [FW-1:0] ins_frame;
  assign ins_frame = is_map ? frame_in : tf;
  logic [FW-1:0] tr_frame;
  assign tr_frame = found ? e_frame[hit_idx] : tf;
  logic [27:0] paddr_c;
  assign paddr_c = 28'((28'(tr_frame) << ob) | 28'(vaddr & ((20'd1 << ob) - 20'd1)));

  always_comb begin
    v_we = 1'b0; v_wd = 1'b0; f_we = 1'b0; f_wd = frame_in;
    if (state == S_CLEAR) begin
      v_we = 1'b1;
    end else if (state == S_UPD && in_range) begin
      if (is_map) begin
        v_we = 1'b1; v_wd = 1'b1; f_we = 1'b1;
      end else if (is_unmap && tv) begin
        v_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      offset_bits <= 4'd4;
      policy <= 1'b0;
      cur_proc <= '0;
      tick <= '0;
      e_valid <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < TLB_SIZE; i++) begin
        e_page[i] <= '0; e_frame[i] <= '0; e_owner[i] <= '0;
        e_ins[i] <= '0; e_use[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == tlbpt_pkg::REG_OFFSET_BITS) offset_bits <= cfg_data;
        else policy <= cfg_data[0];
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(TD - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            act <= s_tdata[1:0];
            vaddr <= s_tdata[21:2];
            page <= s_tdata[29:22];
            frame_in <= FW'(s_tdata[45:30]);
            target <= s_tdata[48:46];
            ob <= cob;
            tick <= tick + 1'b1;
            state <= S_READ;
          end
        end
        S_READ: begin
          scan <= '0;
          found <= 1'b0;
          free_found <= 1'b0;
          pick <= '0;
          oldest <= tick;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan == '0) begin
            tv <= v_rd;
            tf <= v_rd ? f_rd : '0;
          end
          if (match_i && !found) begin
            found <= 1'b1;
            hit_idx <= si;
          end
          if (!free_found) begin
            if (!e_valid[si]) begin
              free_found <= 1'b1;
              pick <= si;
            end else if (!policy) begin
              if (e_ins[si] < oldest) begin
                pick <= si; oldest <= e_ins[si];
              end
            end else if (e_use[si] < e_use[pick]) begin
              pick <= si;
            end
          end
          scan <= scan + 1'b1;
          if (scan == (IW+1)'(TLB_SIZE - 1)) state <= S_UPD;
        end
        S_UPD: begin
          r_status <= tlbpt_pkg::ST_HIT;
          r_paddr <= '0; r_idx <= '0; r_fout <= '0;
          r_pout <= pg_full[7:0];
          if (is_tr) begin
            if (!in_range) r_status <= tlbpt_pkg::ST_FAULT;
            else if (found) begin
              e_use[hit_idx] <= tick;
              r_fout <= 16'(tr_frame); r_idx <= 3'(hit_idx); r_paddr <= paddr_c;
            end else if (tv) begin
              r_status <= tlbpt_pkg::ST_MISS;
              r_fout <= 16'(tf); r_idx <= 3'(ins_idx); r_paddr <= paddr_c;
            end else r_status <= tlbpt_pkg::ST_FAULT;
          end else if (is_map) begin
            if (!in_range) r_status <= tlbpt_pkg::ST_FAULT;
            else begin
              r_status <= tlbpt_pkg::ST_MAPPED;
              r_fout <= 16'(frame_in); r_idx <= 3'(ins_idx);
            end
          end else if (is_unmap) begin
            r_status <= tlbpt_pkg::ST_NOOP;
            if (in_range && tv) begin
              r_status <= tlbpt_pkg::ST_UNMAPPED;
              r_fout <= 16'(tf);
              if (found) begin
                e_valid[hit_idx] <= 1'b0;
                e_frame[hit_idx] <= '0;
              end
            end
          end else begin
            r_pout <= '0;
            if (32'(target) < 32'(PROCESS_COUNT)) cur_proc <= CW'(target);
            else r_status <= tlbpt_pkg::ST_BADPROC;
          end
          if (do_insert) begin
            e_valid[ins_idx] <= 1'b1;
            e_page[ins_idx] <= 8'(pidx);
            e_frame[ins_idx] <= ins_frame;
            e_owner[ins_idx] <= cur_proc;
            e_ins[ins_idx] <= tick;
            e_use[ins_idx] <= tick;
          end
          m_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'd0, 2'(cur_proc), r_pout, r_fout, r_idx, r_paddr, r_status};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while result pending");
  a_one_hit_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (scan == (IW+1)'(TLB_SIZE))) else $error("scan incomplete");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> tick == $past(tick) + 1'b1) else $error("tick");
endmodule

// ===== tb/sv/tlbpt_checker.sv =====
// Checker for the TLB page translator: watches the request, result and
// register-write channels, predicts each result and compares it. Uses tlbpt_pkg.
`timescale 1ns / 1ps
module tlbpt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  localparam int TableDepth = tlbpt_pkg::ProcessCount * tlbpt_pkg::PagesPerProcess;

  typedef struct packed {
    logic [1:0]  process_out;
    logic [7:0]  page_out;
    logic [15:0] frame_out;
    logic [2:0]  entry_index;
    logic [27:0] phys_addr;
    logic [2:0]  status;
  } xlate_result_t;

  logic [3:0]  offset_bits;
  logic        lru_mode;
  logic        ent_valid [tlbpt_pkg::TlbSize];
  logic [7:0]  ent_page [tlbpt_pkg::TlbSize];
  logic [15:0] ent_frame [tlbpt_pkg::TlbSize];
  logic [1:0]  ent_owner [tlbpt_pkg::TlbSize];
  logic [31:0] ent_ins [tlbpt_pkg::TlbSize];
  logic [31:0] ent_use [tlbpt_pkg::TlbSize];
  logic        pt_valid [TableDepth];
  logic [15:0] pt_frame [TableDepth];
  logic [1:0]  cur_proc;
  logic [31:0] tick;
  xlate_result_t expected_results[$];

  function automatic int find_entry(logic [7:0] pg);
    for (int i = 0; i < tlbpt_pkg::TlbSize; i++)
      if (ent_valid[i] && ent_page[i] == pg && ent_owner[i] == cur_proc) begin
        ent_use[i] = tick;
        return i;
      end
    return -1;
  endfunction

  function automatic int fill_entry(logic [7:0] pg, logic [15:0] fr);
    int hit;
    int pick;
    logic [31:0] oldest;
    hit = find_entry(pg);
    pick = 0;
    oldest = tick;
    if (hit >= 0) begin
      ent_frame[hit] = fr;
      ent_ins[hit] = tick;
      ent_use[hit] = tick;
      return hit;
    end
    for (int i = 0; i < tlbpt_pkg::TlbSize; i++) begin
      if (!ent_valid[i]) begin
        pick = i;
        break;
      end
      if (!lru_mode) begin
        if (ent_ins[i] < oldest) begin
          pick = i;
          oldest = ent_ins[i];
        end
      end else if (ent_use[i] < ent_use[pick]) begin
        pick = i;
      end
    end
    ent_valid[pick] = 1'b1;
    ent_page[pick] = pg;
    ent_frame[pick] = fr;
    ent_owner[pick] = cur_proc;
    ent_ins[pick] = tick;
    ent_use[pick] = tick;
    return pick;
  endfunction

  function automatic xlate_result_t translate_item(logic [55:0] d);
    xlate_result_t r;
    logic [1:0] act;
    logic [19:0] va;
    logic [7:0] pg;
    logic [15:0] fr;
    logic [2:0] tgt;
    int ob;
    int e;
    int t;
    logic [19:0] vpn;
    logic [19:0] off;
    act = d[1:0];
    va = d[21:2];
    pg = d[29:22];
    fr = d[45:30];
    tgt = d[48:46];
    ob = (offset_bits > 12) ? 12 : offset_bits;
    r = '0;
    tick = tick + 1;
    case (act)
      tlbpt_pkg::ACT_TRANSLATE: begin
        vpn = va >> ob;
        off = va & ((20'd1 << ob) - 20'd1);
        r.page_out = vpn[7:0];
        r.status = tlbpt_pkg::ST_FAULT;
        if (vpn < tlbpt_pkg::PagesPerProcess) begin
          e = find_entry(vpn[7:0]);
          if (e >= 0) begin
            r.status = tlbpt_pkg::ST_HIT;
            r.frame_out = ent_frame[e];
            r.entry_index = 3'(e);
            r.phys_addr = (28'(ent_frame[e]) << ob) | 28'(off);
          end else begin
            t = cur_proc * tlbpt_pkg::PagesPerProcess + vpn;
            if (pt_valid[t]) begin
              r.status = tlbpt_pkg::ST_MISS;
              r.frame_out = pt_frame[t];
              r.entry_index = 3'(fill_entry(vpn[7:0], pt_frame[t]));
              r.phys_addr = (28'(pt_frame[t]) << ob) | 28'(off);
            end
          end
        end
      end
      tlbpt_pkg::ACT_MAP: begin
        r.page_out = pg;
        t = cur_proc * tlbpt_pkg::PagesPerProcess + pg;
        pt_valid[t] = 1'b1;
        pt_frame[t] = fr;
        r.entry_index = 3'(fill_entry(pg, fr));
        r.frame_out = fr;
        r.status = tlbpt_pkg::ST_MAPPED;
      end
      tlbpt_pkg::ACT_UNMAP: begin
        r.page_out = pg;
        r.status = tlbpt_pkg::ST_NOOP;
        t = cur_proc * tlbpt_pkg::PagesPerProcess + pg;
        if (pt_valid[t]) begin
          r.frame_out = pt_frame[t];
          pt_valid[t] = 1'b0;
          pt_frame[t] = '0;
          for (int i = 0; i < tlbpt_pkg::TlbSize; i++)
            if (ent_valid[i] && ent_page[i] == pg && ent_owner[i] == cur_proc) begin
              ent_valid[i] = 1'b0;
              ent_frame[i] = '0;
              break;
            end
          r.status = tlbpt_pkg::ST_UNMAPPED;
        end
      end
      default: begin
        if (tgt < tlbpt_pkg::ProcessCount) cur_proc = tgt[1:0];
        else r.status = tlbpt_pkg::ST_BADPROC;
      end
    endcase
    r.process_out = cur_proc;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    xlate_result_t got;
    xlate_result_t want;
    if (rst) begin
      offset_bits = 4'd4;
      lru_mode = 1'b0;
      for (int i = 0; i < tlbpt_pkg::TlbSize; i++) begin
        ent_valid[i] = 0; ent_page[i] = 0; ent_frame[i] = 0;
        ent_owner[i] = 0; ent_ins[i] = 0; ent_use[i] = 0;
      end
      for (int i = 0; i < TableDepth; i++) begin
        pt_valid[i] = 0;
        pt_frame[i] = 0;
      end
      cur_proc = 0;
      tick = 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tlbpt_pkg::REG_OFFSET_BITS) offset_bits = cfg_data;
        else lru_mode = cfg_data[0];
      end
      if (s_tvalid && s_tready) expected_results.push_back(translate_item(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[59:0];
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_tdata[63:60] !== 4'd0) begin
            if (fail_count < 10)
              $display("mismatch: st %0d/%0d pa %h/%h idx %0d/%0d fr %h/%h pg %h/%h pr %0d/%0d",
                       want.status, got.status, want.phys_addr,
                       got.phys_addr, want.entry_index, got.entry_index,
                       want.frame_out, got.frame_out, want.page_out, got.page_out,
                       want.process_out, got.process_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the TLB page translator testbench: clock, reset, request and register
// stimulus, verdict. Uses tlbpt_pkg, tlbpt_checker and tlb_page_translator_core.
`timescale 1ns / 1ps
module tb;
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [3:0]  cfg_data;
  int          fail_count;
  int          pending;
  bit          hold_sink;
  bit          sink_run;

  tlb_page_translator_core dut (.*);
  tlbpt_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(logic [1:0] act, logic [19:0] va, logic [7:0] pg,
                           logic [15:0] fr, logic [2:0] tgt);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, tgt, fr, pg, va, act};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  logic [7:0] live_pages[$];

  task automatic random_item(int ob);
    int p;
    logic [7:0] pg;
    p = $urandom_range(0, 99);
    pg = (live_pages.size() != 0 && $urandom_range(0, 2) != 0) ?
         live_pages[$urandom_range(0, live_pages.size() - 1)] : 8'($urandom_range(0, 31));
    if (p < 45)
      send_item(tlbpt_pkg::ACT_TRANSLATE,
                ($urandom_range(0, 9) == 0) ? 20'($urandom) :
                ((20'(pg) << ob) | (20'($urandom) & ((20'd1 << ob) - 1))),
                8'($urandom), 16'($urandom), 3'($urandom));
    else if (p < 75) begin
      send_item(tlbpt_pkg::ACT_MAP, 20'($urandom), pg, 16'($urandom), 3'($urandom));
      live_pages.push_back(pg);
      if (live_pages.size() > 24) void'(live_pages.pop_front());
    end else if (p < 90)
      send_item(tlbpt_pkg::ACT_UNMAP, 20'($urandom), pg, 16'($urandom), 3'($urandom));
    else
      send_item(tlbpt_pkg::ACT_SWITCH, 20'($urandom), 8'($urandom), 16'($urandom),
                3'($urandom_range(0, 4)));
  endtask

  always @(posedge clk) begin
    int sink_gap;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else if (hold_sink) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (!sink_run) begin
      m_tready <= 1'b1;
    end else begin
      sink_gap = gap_len();
      m_tready <= (sink_gap == 0);
    end
  end

  initial begin
    int obs[4];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    hold_sink = 0;
    sink_run = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed
    send_item(tlbpt_pkg::ACT_TRANSLATE, 20'h00010, 0, 0, 0);
    send_item(tlbpt_pkg::ACT_MAP, 0, 8'h00, 16'hFFFF, 0);
    send_item(tlbpt_pkg::ACT_MAP, 0, 8'hFF, 16'h0000, 0);
    send_item(tlbpt_pkg::ACT_TRANSLATE, 20'h0000F, 0, 0, 0);
    send_item(tlbpt_pkg::ACT_TRANSLATE, 20'h00FF5, 0, 0, 0);
    send_item(tlbpt_pkg::ACT_TRANSLATE, 20'hFFFFF, 0, 0, 0);
    send_item(tlbpt_pkg::ACT_MAP, 0, 8'h00, 16'h1234, 0);
    send_item(tlbpt_pkg::ACT_UNMAP, 0, 8'hFF, 0, 0);
    send_item(tlbpt_pkg::ACT_UNMAP, 0, 8'hFF, 0, 0);
    send_item(tlbpt_pkg::ACT_SWITCH, 0, 0, 0, 3'd7);
    send_item(tlbpt_pkg::ACT_SWITCH, 0, 0, 0, 3'd4);
    send_item(tlbpt_pkg::ACT_SWITCH, 0, 0, 0, 3'd3);
    send_item(tlbpt_pkg::ACT_TRANSLATE, 20'h00005, 0, 0, 0);
    for (int i = 0; i < 10; i++)
      send_item(tlbpt_pkg::ACT_MAP, 0, 8'(i + 1), 16'(i * 7 + 1), 0);
    send_item(tlbpt_pkg::ACT_SWITCH, 0, 0, 0, 3'd0);
    send_item(tlbpt_pkg::ACT_TRANSLATE, 20'h00003, 0, 0, 0);
    drain();
    sink_run = 1;
    obs = '{0, 12, 15, 7};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(tlbpt_pkg::REG_OFFSET_BITS,
                (ph < 4) ? 4'(obs[ph]) : 4'($urandom_range(0, 15)));
      write_reg(tlbpt_pkg::REG_POLICY, 4'(ph % 2));
      live_pages.delete();
      if (ph == 2) begin
        fork
          begin
            hold_sink = 1;
            repeat (300) @(posedge clk);
            hold_sink = 0;
          end
        join_none
      end
      for (int i = 0; i < 105; i++)
        random_item((obs[ph % 4] > 12) ? 12 : ((ph < 4) ? obs[ph] : 0));
      drain();
    end
    if (fail_count == 0) $display("tlb_page_translator_core regression: pass");
    else $display("tlb_page_translator_core regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("tlb_page_translator_core regression: fail");
    $finish;
  end
endmodule
